@@ design/rmq_pkg.sv @@
// Shared types and constants for the rotation matrix to quaternion block.
package rmq_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = DATA_WIDTH - 2;
    localparam int ARG_W      = DATA_WIDTH + 3;   // signed working width of trace and arg
    localparam int RAD_W      = 2 * DATA_WIDTH;   // root operand and dividend width
    localparam int REM_W      = DATA_WIDTH + 2;   // root partial remainder width
    localparam int DEN_W      = DATA_WIDTH + 1;   // divisor 2s width

    typedef logic signed [DATA_WIDTH-1:0] fix_t;
    typedef logic signed [ARG_W-1:0]      wide_t;
    typedef logic signed [DATA_WIDTH:0]   num_t;
    typedef logic        [DATA_WIDTH:0]   mag_t;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    typedef struct packed {
        fix_t m11;
        fix_t m12;
        fix_t m13;
        fix_t m21;
        fix_t m22;
        fix_t m23;
        fix_t m31;
        fix_t m32;
        fix_t m33;
    } rmq_in_t;

    typedef struct packed {
        fix_t quat_x;
        fix_t quat_y;
        fix_t quat_z;
        fix_t quat_w;
        logic degenerate;
    } rmq_out_t;

    // carried beside the root pipeline
    typedef struct packed {
        branch_t    branch;
        logic       degen;
        logic [2:0] neg;
        mag_t [2:0] mag;
    } sq_side_t;

    // carried beside the divider pipeline
    typedef struct packed {
        branch_t               branch;
        logic                  degen;
        logic [2:0]            neg;
        logic [DATA_WIDTH-1:0] root;
    } dv_side_t;

endpackage

@@ design/rotation_matrix_to_quaternion.sv @@
// Top level: pipelined rotation matrix to quaternion converter.
//
// Usage:
//   s_* channel takes one word per matrix: nine signed Q2.14 elements.
//   m_* channel returns one word per matrix: quat_x/y/z/w in Q2.14, saturated,
//   plus a degenerate flag set when the root argument was clamped to 1 LSB.
//   Throughput: one matrix per cycle while m_ready stays high.
//   Pipeline stages from accept to m_valid:
//     1 stage   trace, pivot select, root argument, numerators
//     W stages  digit-by-digit square root, one root bit per stage
//     1 stage   divider load: |n| * ONE + s, divisor 2s
//     2W stages three restoring dividers sharing divisor 2s, one quotient
//               bit per stage
//     1 stage   sign, saturation, component placement (output register)
//   The divider chain yields 2W quotient bits, one per stage.
//   Stall: when m_valid is high and m_ready low the whole pipeline holds;
//   s_ready drops in the same cycle, so nothing is lost or repeated.
//   Reset (aresetn low, synchronous): all stage valid bits clear, m_valid
//   goes low; data registers keep whatever they hold.
module rotation_matrix_to_quaternion (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rmq_pkg::rmq_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rmq_pkg::rmq_out_t m_data
);
    import rmq_pkg::*;

    localparam int SQ_N = DATA_WIDTH;   // root stages
    localparam int DV_N = RAD_W;        // divider stages
    localparam logic [RAD_W-1:0] Q_POS_MAX = (RAD_W'(1) << (DATA_WIDTH - 1)) - RAD_W'(1);
    localparam logic [RAD_W-1:0] Q_NEG_MAX = RAD_W'(1) << (DATA_WIDTH - 1);
    localparam fix_t SAT_MAX = fix_t'(Q_POS_MAX[DATA_WIDTH-1:0]);
    localparam fix_t SAT_MIN = fix_t'(Q_NEG_MAX[DATA_WIDTH-1:0]);

    logic adv;   // whole pipeline moves one stage

    // ---------------- entry stage ----------------
    wide_t   e11, e22, e33, trace, arg;
    branch_t branch;
    logic    degen;
    num_t    n_a, n_b, n_c;
    sq_side_t side0;

    always_comb begin
        e11   = wide_t'(s_data.m11);
        e22   = wide_t'(s_data.m22);
        e33   = wide_t'(s_data.m33);
        trace = e11 + e22 + e33;
        if (trace > 0) begin
            branch = BR_TRACE;
            arg    = trace + (wide_t'(1) <<< FRAC_BITS);
            n_a    = num_t'(s_data.m23) - num_t'(s_data.m32);
            n_b    = num_t'(s_data.m31) - num_t'(s_data.m13);
            n_c    = num_t'(s_data.m12) - num_t'(s_data.m21);
        end else if (e11 >= e22 && e11 >= e33) begin
            branch = BR_X;
            arg    = (wide_t'(1) <<< FRAC_BITS) + e11 - e22 - e33;
            n_a    = num_t'(s_data.m12) + num_t'(s_data.m21);
            n_b    = num_t'(s_data.m13) + num_t'(s_data.m31);
            n_c    = num_t'(s_data.m23) - num_t'(s_data.m32);
        end else if (e22 > e33) begin
            branch = BR_Y;
            arg    = (wide_t'(1) <<< FRAC_BITS) + e22 - e11 - e33;
            n_a    = num_t'(s_data.m21) + num_t'(s_data.m12);
            n_b    = num_t'(s_data.m32) + num_t'(s_data.m23);
            n_c    = num_t'(s_data.m31) - num_t'(s_data.m13);
        end else begin
            branch = BR_Z;
            arg    = (wide_t'(1) <<< FRAC_BITS) + e33 - e11 - e22;
            n_a    = num_t'(s_data.m31) + num_t'(s_data.m13);
            n_b    = num_t'(s_data.m32) + num_t'(s_data.m23);
            n_c    = num_t'(s_data.m12) - num_t'(s_data.m21);
        end
        degen = (arg <= 0);
        if (degen) begin
            arg = wide_t'(1);
        end
        side0.branch = branch;
        side0.degen  = degen;
        side0.neg    = {n_c[DATA_WIDTH], n_b[DATA_WIDTH], n_a[DATA_WIDTH]};
        side0.mag[0] = n_a[DATA_WIDTH] ? mag_t'(-n_a) : mag_t'(n_a);
        side0.mag[1] = n_b[DATA_WIDTH] ? mag_t'(-n_b) : mag_t'(n_b);
        side0.mag[2] = n_c[DATA_WIDTH] ? mag_t'(-n_c) : mag_t'(n_c);
    end

    // ---------------- root pipeline ----------------
    // index 0 is the entry register; stage k builds index k+1
    logic                  sq_valid_reg [SQ_N+1];
    logic [RAD_W-1:0]      sq_op_reg    [SQ_N+1];
    logic [REM_W-1:0]      sq_rem_reg   [SQ_N+1];
    logic [DATA_WIDTH-1:0] sq_root_reg  [SQ_N+1];
    sq_side_t              sq_side_reg  [SQ_N+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_valid_reg[0] <= s_valid;
        end
        if (adv) begin
            sq_op_reg[0]   <= {arg[REM_W-1:0], {FRAC_BITS{1'b0}}};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_side_reg[0] <= side0;
        end
    end

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        logic [REM_W+1:0]      trial;
        logic [REM_W+1:0]      sub;
        logic [REM_W-1:0]      rem_next;
        logic [DATA_WIDTH-1:0] root_next;

        always_comb begin
            trial = {sq_rem_reg[k], sq_op_reg[k][RAD_W-1 -: 2]};
            sub   = (REM_W+2)'({sq_root_reg[k], 2'b01});
            if (trial >= sub) begin
                rem_next  = REM_W'(trial - sub);
                root_next = {sq_root_reg[k][DATA_WIDTH-2:0], 1'b1};
            end else begin
                rem_next  = REM_W'(trial);
                root_next = {sq_root_reg[k][DATA_WIDTH-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
            if (adv) begin
                sq_op_reg[k+1]   <= {sq_op_reg[k][RAD_W-3:0], 2'b00};
                sq_rem_reg[k+1]  <= rem_next;
                sq_root_reg[k+1] <= root_next;
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // ---------------- divider pipeline ----------------
    logic                  dv_valid_reg [DV_N+1];
    logic [DEN_W-1:0]      dv_rem_reg   [DV_N+1][3];
    logic [RAD_W-1:0]      dv_q_reg     [DV_N+1][3];
    dv_side_t              dv_side_reg  [DV_N+1];
    logic [DATA_WIDTH-1:0] s_root;

    assign s_root = sq_root_reg[SQ_N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_valid_reg[0] <= sq_valid_reg[SQ_N];
        end
        if (adv) begin
            for (int l = 0; l < 3; l++) begin
                // (|n| * ONE + s), rounding half away from zero after / 2s
                dv_q_reg[0][l]   <= {sq_side_reg[SQ_N].mag[l], {FRAC_BITS{1'b0}}}
                                    + RAD_W'(s_root);
                dv_rem_reg[0][l] <= '0;
            end
            dv_side_reg[0].branch <= sq_side_reg[SQ_N].branch;
            dv_side_reg[0].degen  <= sq_side_reg[SQ_N].degen;
            dv_side_reg[0].neg    <= sq_side_reg[SQ_N].neg;
            dv_side_reg[0].root   <= s_root;
        end
    end

    for (genvar j = 0; j < DV_N; j++) begin : g_div
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem_next [3];
        logic [RAD_W-1:0] q_next   [3];

        assign den = {dv_side_reg[j].root, 1'b0};

        always_comb begin
            logic [DEN_W:0] t;
            for (int l = 0; l < 3; l++) begin
                t = {dv_rem_reg[j][l], dv_q_reg[j][l][RAD_W-1]};
                if (t >= {1'b0, den}) begin
                    rem_next[l] = DEN_W'(t - {1'b0, den});
                    q_next[l]   = {dv_q_reg[j][l][RAD_W-2:0], 1'b1};
                end else begin
                    rem_next[l] = DEN_W'(t);
                    q_next[l]   = {dv_q_reg[j][l][RAD_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[j+1] <= 1'b0;
            end else if (adv) begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
            if (adv) begin
                for (int l = 0; l < 3; l++) begin
                    dv_rem_reg[j+1][l] <= rem_next[l];
                    dv_q_reg[j+1][l]   <= q_next[l];
                end
                dv_side_reg[j+1] <= dv_side_reg[j];
            end
        end
    end

    // ---------------- sign, saturate, place ----------------
    fix_t     lane [3];
    fix_t     pivot;
    rmq_out_t res;
    dv_side_t fin;

    assign fin = dv_side_reg[DV_N];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (fin.neg[l]) begin
                lane[l] = (dv_q_reg[DV_N][l] > Q_NEG_MAX) ? SAT_MIN
                        : fix_t'(-dv_q_reg[DV_N][l][DATA_WIDTH-1:0]);
            end else begin
                lane[l] = (dv_q_reg[DV_N][l] > Q_POS_MAX) ? SAT_MAX
                        : fix_t'(dv_q_reg[DV_N][l][DATA_WIDTH-1:0]);
            end
        end
        pivot          = fix_t'({1'b0, fin.root[DATA_WIDTH-1:1]});
        res.degenerate = fin.degen;
        unique case (fin.branch)
            BR_TRACE: begin
                res.quat_x = lane[0];
                res.quat_y = lane[1];
                res.quat_z = lane[2];
                res.quat_w = pivot;
            end
            BR_X: begin
                res.quat_x = pivot;
                res.quat_y = lane[0];
                res.quat_z = lane[1];
                res.quat_w = lane[2];
            end
            BR_Y: begin
                res.quat_x = lane[0];
                res.quat_y = pivot;
                res.quat_z = lane[1];
                res.quat_w = lane[2];
            end
            default: begin
                res.quat_x = lane[0];
                res.quat_y = lane[1];
                res.quat_z = pivot;
                res.quat_w = lane[2];
            end
        endcase
    end

    logic     m_valid_reg;
    rmq_out_t m_data_reg;

    // output register stalls the chain only while a word waits
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_valid_reg[DV_N];
        end
        if (adv) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ design/rmq_checker.sv @@
// Port-level checker for the rotation matrix to quaternion block, with bind.
module rmq_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input rmq_pkg::rmq_out_t m_data
);
    import rmq_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed under stall");

    // input side only waits while a result word is stalled
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow output stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ tb/tb_rotation_matrix_to_quaternion.sv @@
// Testbench for the rotation matrix to quaternion converter: predicted results, random flow.
module tb_rotation_matrix_to_quaternion;
    timeunit 1ns;
    timeprecision 1ps;
    import rmq_pkg::*;

    localparam longint ONE_Q   = 64'sd1 << FRAC_BITS;
    localparam longint SAT_HI  = (64'sd1 << (DATA_WIDTH - 1)) - 1;
    localparam longint SAT_LO  = -SAT_HI - 1;
    localparam int     LATENCY = 3 * DATA_WIDTH + 3;
    localparam int     N_RAND  = 1350;
    localparam longint LIMIT   = 400000;

    // Quaternion predictor and in-order store of expected words.
    class quat_board;
        rmq_out_t pending[$];
        int       errors = 0;

        function automatic longint root_floor(longint v);
            longint r;
            longint b;
            r = 0;
            b = 64'sd1 << 62;
            while (b > v) b = b >>> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >>> 1) + b;
                end else begin
                    r = r >>> 1;
                end
                b = b >>> 2;
            end
            return r;
        endfunction

        // n / 2s, rounded to nearest, ties away from zero
        function automatic longint half_div(longint n, longint s);
            longint q;
            q = (((n < 0) ? -n : n) * ONE_Q + s) / (2 * s);
            return (n < 0) ? -q : q;
        endfunction

        function automatic fix_t clip(longint v);
            if (v > SAT_HI) v = SAT_HI;
            if (v < SAT_LO) v = SAT_LO;
            return fix_t'(v);
        endfunction

        function void note_matrix(rmq_in_t m);
            longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
            longint tr, arg, s, qx, qy, qz, qw;
            branch_t br;
            rmq_out_t e;
            a11 = m.m11; a12 = m.m12; a13 = m.m13;
            a21 = m.m21; a22 = m.m22; a23 = m.m23;
            a31 = m.m31; a32 = m.m32; a33 = m.m33;
            tr = a11 + a22 + a33;
            e.degenerate = 1'b0;
            if (tr > 0) begin
                br = BR_TRACE; arg = tr + ONE_Q;
            end else if (a11 >= a22 && a11 >= a33) begin
                br = BR_X; arg = ONE_Q + a11 - a22 - a33;
            end else if (a22 > a33) begin
                br = BR_Y; arg = ONE_Q + a22 - a11 - a33;
            end else begin
                br = BR_Z; arg = ONE_Q + a33 - a11 - a22;
            end
            if (arg <= 0) begin
                arg = 1;
                e.degenerate = 1'b1;
            end
            s = root_floor(arg * ONE_Q);
            case (br)
                BR_TRACE: begin
                    qw = s >>> 1; qx = half_div(a23 - a32, s);
                    qy = half_div(a31 - a13, s); qz = half_div(a12 - a21, s);
                end
                BR_X: begin
                    qx = s >>> 1; qy = half_div(a12 + a21, s);
                    qz = half_div(a13 + a31, s); qw = half_div(a23 - a32, s);
                end
                BR_Y: begin
                    qx = half_div(a21 + a12, s); qy = s >>> 1;
                    qz = half_div(a32 + a23, s); qw = half_div(a31 - a13, s);
                end
                default: begin
                    qx = half_div(a31 + a13, s); qy = half_div(a32 + a23, s);
                    qz = s >>> 1; qw = half_div(a12 - a21, s);
                end
            endcase
            e.quat_x = clip(qx);
            e.quat_y = clip(qy);
            e.quat_z = clip(qz);
            e.quat_w = clip(qw);
            pending.push_back(e);
        endfunction

        function void check_quat(rmq_out_t got);
            rmq_out_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $realtime, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.quat_x !== e.quat_x) begin
                $display("%0t: quat_x exp %0d got %0d", $realtime, e.quat_x, got.quat_x);
                errors++;
            end
            if (got.quat_y !== e.quat_y) begin
                $display("%0t: quat_y exp %0d got %0d", $realtime, e.quat_y, got.quat_y);
                errors++;
            end
            if (got.quat_z !== e.quat_z) begin
                $display("%0t: quat_z exp %0d got %0d", $realtime, e.quat_z, got.quat_z);
                errors++;
            end
            if (got.quat_w !== e.quat_w) begin
                $display("%0t: quat_w exp %0d got %0d", $realtime, e.quat_w, got.quat_w);
                errors++;
            end
            if (got.degenerate !== e.degenerate) begin
                $display("%0t: degenerate exp %0b got %0b", $realtime,
                         e.degenerate, got.degenerate);
                errors++;
            end
        endfunction
    endclass

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    rmq_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rmq_out_t m_data;

    quat_board board = new();
    longint    cycles = 0;
    bit        stall_on = 1'b0;   // receiver stalls only while set

    rotation_matrix_to_quaternion dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Result side: sample at the rising edge, check accepted words.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) board.check_quat(m_data);
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver stall pattern: long runs of ready, occasional stall bursts.
    int stall_left = 0;
    always @(negedge aclk) begin
        if (!stall_on) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 12);
        end
    end

    // Drive one word: present at the falling edge, hold until accepted.
    task automatic send_word(rmq_in_t w);
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.note_matrix(w);
        @(negedge aclk);
    endtask

    task automatic pause(int n);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    function automatic fix_t rand_fix();
        return fix_t'($urandom());
    endfunction

    function automatic fix_t near(int v, int spread);
        return fix_t'(v + $urandom_range(0, 2 * spread) - spread);
    endfunction

    // Rotation-like matrix from a random quaternion (in Q2.14).
    function automatic rmq_in_t rot_matrix();
        real a, b, c, d, n;
        rmq_in_t r;
        a = $urandom_range(0, 20000) - 10000.0;
        b = $urandom_range(0, 20000) - 10000.0;
        c = $urandom_range(0, 20000) - 10000.0;
        d = $urandom_range(0, 20000) - 10000.0;
        n = $sqrt(a*a + b*b + c*c + d*d) + 1.0;
        a = a / n; b = b / n; c = c / n; d = d / n;
        r.m11 = fix_t'($rtoi(16384.0 * (1 - 2*(c*c + d*d))));
        r.m12 = fix_t'($rtoi(16384.0 * 2*(b*c + d*a)));
        r.m13 = fix_t'($rtoi(16384.0 * 2*(b*d - c*a)));
        r.m21 = fix_t'($rtoi(16384.0 * 2*(b*c - d*a)));
        r.m22 = fix_t'($rtoi(16384.0 * (1 - 2*(b*b + d*d))));
        r.m23 = fix_t'($rtoi(16384.0 * 2*(c*d + b*a)));
        r.m31 = fix_t'($rtoi(16384.0 * 2*(b*d + c*a)));
        r.m32 = fix_t'($rtoi(16384.0 * 2*(c*d - b*a)));
        r.m33 = fix_t'($rtoi(16384.0 * (1 - 2*(b*b + c*c))));
        return r;
    endfunction

    initial begin
        rmq_in_t w;
        int      burst;
        int      k;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: identity, pivots, extremes, non-positive trace, ties.
        w = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};  send_word(w);
        w = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_word(w);
        w = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_word(w);
        w = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_word(w);
        w = '0;                                          send_word(w);
        w = '1;                                          send_word(w);
        w = {9{16'sh7fff}};                              send_word(w);
        w = {9{16'sh8000}};                              send_word(w);
        // trace not positive: pivot branches, pivot argument still positive
        w = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
        send_word(w);
        w = '{0, 32767, 32767, -32768, 0, 32767, -32768, -32768, 0}; send_word(w);
        w = '{-20000, 1, 0, 0, -20000, 0, 0, 0, -20000};            send_word(w);
        // trace zero or negative, ties among diagonal, then positive traces
        w = '{0, 100, -100, 3, 0, 7, -9, 5, 0};                      send_word(w);
        w = '{-5, 1, 2, 3, 5, 4, 6, 7, 0};                           send_word(w);
        w = '{-5, 1, 2, 3, -2, 4, 6, 7, -2};                         send_word(w);
        w = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
        send_word(w);
        w = '{16384, 32767, -32768, -32768, 16384, 32767, 32767, -32768, 16384};
        send_word(w);
        w = '{1, 0, 0, 0, 0, 0, 0, 0, 0};                            send_word(w);

        // Hold-off: let the pipeline drain fully.
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
        stall_on = 1'b1;

        k = 0;
        while (k < N_RAND) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && k < N_RAND) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        w = {rand_fix(), rand_fix(), rand_fix(), rand_fix(), rand_fix(),
                             rand_fix(), rand_fix(), rand_fix(), rand_fix()};
                    end
                    2: begin
                        // diagonal near -1.0 for non-positive trace and near-tie cases
                        w = rot_matrix();
                        w.m11 = near(-16384, 40); w.m22 = near(-16384, 40);
                        w.m33 = near(-16384, 40);
                    end
                    default: w = rot_matrix();
                endcase
                send_word(w);
                burst--;
                k++;
            end
            if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 15));
            if (k > 600 && k < 640) stall_on = 1'b0;
            else stall_on = 1'b1;
        end
        s_valid <= 1'b0;

        while (board.pending.size() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
        if (board.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
